// ===== design/stage_dot_to_framebuffer_plot_macros.svh =====
`ifndef STAGE_DOT_TO_FRAMEBUFFER_PLOT_MACROS_SVH
`define STAGE_DOT_TO_FRAMEBUFFER_PLOT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDFP_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdfp: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdfp: next-cycle check failed");

`endif

// ===== design/sdfp_pkg.sv =====
`default_nettype none

package sdfp_pkg;

  localparam int SCREEN_WIDTH  = 400;
  localparam int SCREEN_HEIGHT = 240;

  localparam int XY_W   = 32;
  localparam int ID_W   = 16;
  localparam int CFG_W  = 16;
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;
  localparam int OFF_W  = 17;
  localparam int COL_W  = 16;
  localparam int FRAC_W = 16;

  // dividends of the two scale divisions (screen size in 16.16)
  localparam longint NUM_X = longint'(SCREEN_WIDTH) << FRAC_W;
  localparam longint NUM_Y = longint'(SCREEN_HEIGHT) << FRAC_W;
  localparam longint NUM_MAX = (NUM_X > NUM_Y) ? NUM_X : NUM_Y;
  localparam int DIV_W = $clog2(NUM_MAX + 1);
  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] NUM_X_C = DIV_W'(NUM_X);
  localparam logic [DIV_W-1:0] NUM_Y_C = DIV_W'(NUM_Y);

  // stage position times scale, and the floored position plus offset
  localparam int PROD_W = XY_W + DIV_W + 1;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;

  localparam logic [31:0] HASH_MUL    = 32'd2654435761;
  localparam logic [7:0]  COLOR_FLOOR = 8'h40;

  typedef enum logic [0:0] {
    CFG_STAGE_WIDTH  = 1'b0,
    CFG_STAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_DIV,
    SC_MIN,
    SC_MUL,
    SC_OFF
  } sc_state_t;

  typedef struct packed {
    logic             ready;
    logic             bypass;
    logic [DIV_W-1:0] scale;
    logic [SX_W-1:0]  off_x;
    logic [SY_W-1:0]  off_y;
  } scale_t;

  function automatic logic [COL_W-1:0] dot_color(input logic [31:0] h);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = h[23:16] | COLOR_FLOOR;
    g = h[15:8]  | COLOR_FLOOR;
    b = h[7:0]   | COLOR_FLOOR;
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== design/stage_dot_to_framebuffer_plot.sv =====
// Channel   Handshake            Payload
// in        in_valid/in_ready    in_stage_x, in_stage_y, in_character_id
// out       out_valid/out_ready  out_screen_x, out_screen_y, out_pixel_offset, out_pixel_color
// cfg       cfg_we               cfg_index, cfg_wdata (no wait, no read-back)
//
// One transaction per cycle through three register stages, while the output is not stalled
// and no scale computation runs; out_valid is the valid bit of the third stage.
// After each cfg write, in_ready is low while the scale is recomputed: a restoring
// division per axis, side by side (one quotient bit a cycle), then min, multiply, center.
// After reset the stage size is zero and points are clamped directly.
// A stall at the output fills empty stages first; nothing is lost or repeated.
`default_nettype none
`include "stage_dot_to_framebuffer_plot_macros.svh"

module stage_dot_to_framebuffer_plot (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [sdfp_pkg::XY_W-1:0]  in_stage_x,
  input  wire logic signed [sdfp_pkg::XY_W-1:0]  in_stage_y,
  input  wire logic [sdfp_pkg::ID_W-1:0]         in_character_id,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sdfp_pkg::SX_W-1:0]              out_screen_x,
  output logic [sdfp_pkg::SY_W-1:0]              out_screen_y,
  output logic [sdfp_pkg::OFF_W-1:0]             out_pixel_offset,
  output logic [sdfp_pkg::COL_W-1:0]             out_pixel_color,
  input  wire logic                              cfg_we,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [sdfp_pkg::CFG_W-1:0]        cfg_wdata
);

  sdfp_pkg::scale_t           scale;
  logic                       on_screen;
  logic [sdfp_pkg::OFF_W-1:0] offset_chk;

  sdfp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .scale     (scale)
  );

  sdfp_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .scale            (scale),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stage_x       (in_stage_x),
    .in_stage_y       (in_stage_y),
    .in_character_id  (in_character_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_color  (out_pixel_color)
  );

  assign on_screen  = (out_screen_x <= sdfp_pkg::SX_W'(sdfp_pkg::SCREEN_WIDTH - 1))
                   && (out_screen_y <= sdfp_pkg::SY_W'(sdfp_pkg::SCREEN_HEIGHT - 1));
  assign offset_chk = sdfp_pkg::OFF_W'(out_screen_x) * sdfp_pkg::OFF_W'(sdfp_pkg::SCREEN_HEIGHT)
                    + sdfp_pkg::OFF_W'(sdfp_pkg::SCREEN_HEIGHT - 1)
                    - sdfp_pkg::OFF_W'(out_screen_y);

  `SDFP_ASSERT_HOLDS(a_busy_blocks_input, !scale.ready, !in_ready)
  `SDFP_ASSERT_HOLDS(a_out_on_screen, out_valid, on_screen)
  `SDFP_ASSERT_HOLDS(a_offset_matches, out_valid, out_pixel_offset == offset_chk)

endmodule

`default_nettype wire

// ===== design/sdfp_scale.sv =====
`default_nettype none
`include "stage_dot_to_framebuffer_plot_macros.svh"

module sdfp_scale (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [sdfp_pkg::CFG_W-1:0] cfg_wdata,
  output sdfp_pkg::scale_t               scale
);

  localparam int PW_W = sdfp_pkg::CFG_W + sdfp_pkg::DIV_W;

  logic [sdfp_pkg::CFG_W-1:0] w_r;
  logic [sdfp_pkg::CFG_W-1:0] h_r;
  sdfp_pkg::sc_state_t        state_r;
  sdfp_pkg::sc_state_t        state_nxt;
  logic [sdfp_pkg::CNT_W-1:0] cnt_r;
  logic [sdfp_pkg::DIV_W-1:0] qx_r;
  logic [sdfp_pkg::DIV_W-1:0] qy_r;
  logic [sdfp_pkg::CFG_W-1:0] rx_r;
  logic [sdfp_pkg::CFG_W-1:0] ry_r;
  logic [sdfp_pkg::DIV_W-1:0] s_r;
  logic [PW_W-1:0]            pw_r;
  logic [PW_W-1:0]            ph_r;
  logic [sdfp_pkg::SX_W-1:0]  ox_r;
  logic [sdfp_pkg::SY_W-1:0]  oy_r;

  logic                       idle;
  logic                       div_step;
  logic                       min_step;
  logic                       mul_step;
  logic                       off_step;
  logic                       bypass;
  logic [sdfp_pkg::CFG_W:0]   trial_x;
  logic [sdfp_pkg::CFG_W:0]   trial_y;
  logic                       ge_x;
  logic                       ge_y;
  logic [sdfp_pkg::CFG_W-1:0] rx_nxt;
  logic [sdfp_pkg::CFG_W-1:0] ry_nxt;
  logic [sdfp_pkg::SX_W:0]    dx;
  logic [sdfp_pkg::SY_W:0]    dy;
  logic                       center_fits;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      h_r <= '0;
    end else if (cfg_we) begin
      unique case (sdfp_pkg::cfg_idx_t'(cfg_index))
        sdfp_pkg::CFG_STAGE_WIDTH:  w_r <= cfg_wdata;
        sdfp_pkg::CFG_STAGE_HEIGHT: h_r <= cfg_wdata;
      endcase
    end
  end

  // next state: any write restarts the scale computation
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdfp_pkg::SC_IDLE: state_nxt = sdfp_pkg::SC_IDLE;
      sdfp_pkg::SC_DIV:  if (cnt_r == '0) state_nxt = sdfp_pkg::SC_MIN;
      sdfp_pkg::SC_MIN:  state_nxt = sdfp_pkg::SC_MUL;
      sdfp_pkg::SC_MUL:  state_nxt = sdfp_pkg::SC_OFF;
      sdfp_pkg::SC_OFF:  state_nxt = sdfp_pkg::SC_IDLE;
      default:           state_nxt = sdfp_pkg::SC_IDLE;
    endcase
    if (cfg_we) state_nxt = sdfp_pkg::SC_DIV;
  end

  // state decodes
  always_comb begin
    idle     = 1'b0;
    div_step = 1'b0;
    min_step = 1'b0;
    mul_step = 1'b0;
    off_step = 1'b0;
    unique case (state_r)
      sdfp_pkg::SC_IDLE: idle     = 1'b1;
      sdfp_pkg::SC_DIV:  div_step = 1'b1;
      sdfp_pkg::SC_MIN:  min_step = 1'b1;
      sdfp_pkg::SC_MUL:  mul_step = 1'b1;
      sdfp_pkg::SC_OFF:  off_step = 1'b1;
      default:           idle     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdfp_pkg::SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // restoring division, one quotient bit per cycle for both axes
  assign trial_x = {rx_r, sdfp_pkg::NUM_X_C[cnt_r]};
  assign trial_y = {ry_r, sdfp_pkg::NUM_Y_C[cnt_r]};
  assign ge_x    = trial_x >= {1'b0, w_r};
  assign ge_y    = trial_y >= {1'b0, h_r};
  assign rx_nxt  = ge_x ? sdfp_pkg::CFG_W'(trial_x - {1'b0, w_r}) : trial_x[sdfp_pkg::CFG_W-1:0];
  assign ry_nxt  = ge_y ? sdfp_pkg::CFG_W'(trial_y - {1'b0, h_r}) : trial_y[sdfp_pkg::CFG_W-1:0];

  // centering: half of what the scaled stage leaves free
  assign dx = (sdfp_pkg::SX_W + 1)'(sdfp_pkg::SCREEN_WIDTH)
            - {1'b0, pw_r[sdfp_pkg::FRAC_W +: sdfp_pkg::SX_W]};
  assign dy = (sdfp_pkg::SY_W + 1)'(sdfp_pkg::SCREEN_HEIGHT)
            - {1'b0, ph_r[sdfp_pkg::FRAC_W +: sdfp_pkg::SY_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= sdfp_pkg::CNT_W'(sdfp_pkg::DIV_W - 1);
    end else if (div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      rx_r <= '0;
      ry_r <= '0;
    end else if (div_step) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      qx_r <= {qx_r[sdfp_pkg::DIV_W-2:0], ge_x};
      qy_r <= {qy_r[sdfp_pkg::DIV_W-2:0], ge_y};
    end
    if (min_step) s_r <= (qx_r < qy_r) ? qx_r : qy_r;
    if (mul_step) begin
      pw_r <= PW_W'(w_r) * PW_W'(s_r);
      ph_r <= PW_W'(h_r) * PW_W'(s_r);
    end
    if (off_step) begin
      ox_r <= dx[sdfp_pkg::SX_W:1];
      oy_r <= dy[sdfp_pkg::SY_W:1];
    end
  end

  assign bypass       = (w_r == '0) || (h_r == '0);
  assign scale.ready  = idle;
  assign scale.bypass = bypass;
  assign scale.scale  = s_r;
  assign scale.off_x  = ox_r;
  assign scale.off_y  = oy_r;

  assign center_fits = (ox_r <= sdfp_pkg::SX_W'(sdfp_pkg::SCREEN_WIDTH / 2))
                    && (oy_r <= sdfp_pkg::SY_W'(sdfp_pkg::SCREEN_HEIGHT / 2));

  `SDFP_ASSERT_NEXT(a_write_restarts, cfg_we, state_r == sdfp_pkg::SC_DIV)
  `SDFP_ASSERT_HOLDS(a_scale_nonzero, idle && !bypass, s_r != '0)
  `SDFP_ASSERT_HOLDS(a_center_fits, idle && !bypass, center_fits)

endmodule

`default_nettype wire

// ===== design/sdfp_pipe.sv =====
`default_nettype none

module sdfp_pipe (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sdfp_pkg::scale_t                  scale,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [sdfp_pkg::XY_W-1:0]  in_stage_x,
  input  wire logic signed [sdfp_pkg::XY_W-1:0]  in_stage_y,
  input  wire logic [sdfp_pkg::ID_W-1:0]         in_character_id,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sdfp_pkg::SX_W-1:0]              out_screen_x,
  output logic [sdfp_pkg::SY_W-1:0]              out_screen_y,
  output logic [sdfp_pkg::OFF_W-1:0]             out_pixel_offset,
  output logic [sdfp_pkg::COL_W-1:0]             out_pixel_color
);

  localparam int PROD_W = sdfp_pkg::PROD_W;
  localparam int SUM_W  = sdfp_pkg::SUM_W;
  localparam int SX_W   = sdfp_pkg::SX_W;
  localparam int SY_W   = sdfp_pkg::SY_W;
  localparam int OFF_W  = sdfp_pkg::OFF_W;

  logic ld1;
  logic ld2;
  logic ld3;
  logic in_fire;

  logic v1_r;
  logic v2_r;
  logic v3_r;

  // stage 1: products, direct clamp, hash
  logic signed [sdfp_pkg::DIV_W:0] s_sgn;
  logic signed [PROD_W-1:0]        mx;
  logic signed [PROD_W-1:0]        my;
  logic [SX_W-1:0]                 cx;
  logic [SY_W-1:0]                 cy;
  logic [31:0]                     hh;
  logic signed [PROD_W-1:0]        px1_r;
  logic signed [PROD_W-1:0]        py1_r;
  logic [SX_W-1:0]                 cx1_r;
  logic [SY_W-1:0]                 cy1_r;
  logic [31:0]                     h1_r;

  // stage 2: floor, center, clamp, color
  logic signed [SUM_W-1:0]         sum_x;
  logic signed [SUM_W-1:0]         sum_y;
  logic [SX_W-1:0]                 fx;
  logic [SY_W-1:0]                 fy;
  logic [SX_W-1:0]                 sx2_r;
  logic [SY_W-1:0]                 sy2_r;
  logic [sdfp_pkg::COL_W-1:0]      col2_r;

  // stage 3: output register
  logic [SX_W-1:0]                 sx3_r;
  logic [SY_W-1:0]                 sy3_r;
  logic [OFF_W-1:0]                off3_r;
  logic [sdfp_pkg::COL_W-1:0]      col3_r;

  // a stage loads when it is empty or its contents move on
  assign ld3      = !v3_r || out_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1 && scale.ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_fire;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  assign s_sgn = $signed({1'b0, scale.scale});
  assign mx    = PROD_W'(in_stage_x) * PROD_W'(s_sgn);
  assign my    = PROD_W'(in_stage_y) * PROD_W'(s_sgn);
  assign hh    = 32'({16'b0, in_character_id}) * sdfp_pkg::HASH_MUL;

  always_comb begin
    if (in_stage_x < 0) begin
      cx = '0;
    end else if (in_stage_x > $signed(sdfp_pkg::XY_W'(sdfp_pkg::SCREEN_WIDTH - 1))) begin
      cx = SX_W'(sdfp_pkg::SCREEN_WIDTH - 1);
    end else begin
      cx = in_stage_x[SX_W-1:0];
    end
    if (in_stage_y < 0) begin
      cy = '0;
    end else if (in_stage_y > $signed(sdfp_pkg::XY_W'(sdfp_pkg::SCREEN_HEIGHT - 1))) begin
      cy = SY_W'(sdfp_pkg::SCREEN_HEIGHT - 1);
    end else begin
      cy = in_stage_y[SY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_fire) begin
      px1_r <= mx;
      py1_r <= my;
      cx1_r <= cx;
      cy1_r <= cy;
      h1_r  <= hh;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign sum_x = SUM_W'(px1_r >>> sdfp_pkg::FRAC_W) + SUM_W'($signed({1'b0, scale.off_x}));
  assign sum_y = SUM_W'(py1_r >>> sdfp_pkg::FRAC_W) + SUM_W'($signed({1'b0, scale.off_y}));

  always_comb begin
    if (sum_x < 0) begin
      fx = '0;
    end else if (sum_x > $signed(SUM_W'(sdfp_pkg::SCREEN_WIDTH - 1))) begin
      fx = SX_W'(sdfp_pkg::SCREEN_WIDTH - 1);
    end else begin
      fx = sum_x[SX_W-1:0];
    end
    if (sum_y < 0) begin
      fy = '0;
    end else if (sum_y > $signed(SUM_W'(sdfp_pkg::SCREEN_HEIGHT - 1))) begin
      fy = SY_W'(sdfp_pkg::SCREEN_HEIGHT - 1);
    end else begin
      fy = sum_y[SY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      sx2_r  <= scale.bypass ? cx1_r : fx;
      sy2_r  <= scale.bypass ? cy1_r : fy;
      col2_r <= sdfp_pkg::dot_color(h1_r);
    end
  end

  // rotated framebuffer: column-major, rows counted from the bottom
  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      off3_r <= OFF_W'(sx2_r) * OFF_W'(sdfp_pkg::SCREEN_HEIGHT)
              + OFF_W'(sdfp_pkg::SCREEN_HEIGHT - 1) - OFF_W'(sy2_r);
      col3_r <= col2_r;
    end
  end

  assign out_valid        = v3_r;
  assign out_screen_x     = sx3_r;
  assign out_screen_y     = sy3_r;
  assign out_pixel_offset = off3_r;
  assign out_pixel_color  = col3_r;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          XY_W          = sdfp_pkg::XY_W;
  localparam int          ID_W          = sdfp_pkg::ID_W;
  localparam int          SX_W          = sdfp_pkg::SX_W;
  localparam int          SY_W          = sdfp_pkg::SY_W;
  localparam int          OFF_W         = sdfp_pkg::OFF_W;
  localparam int          COL_W         = sdfp_pkg::COL_W;
  localparam int          CFG_W         = sdfp_pkg::CFG_W;
  localparam int          SCREEN_WIDTH  = sdfp_pkg::SCREEN_WIDTH;
  localparam int          SCREEN_HEIGHT = sdfp_pkg::SCREEN_HEIGHT;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          N_FIXED     = 10;
  localparam int          N_PHASES    = N_FIXED + 3;
  localparam int          PHASE_ITEMS = 112;
  localparam logic [31:0] GOLDEN_MUL  = 32'd2654435761;

  typedef struct {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ID_W-1:0]        id;
  } dot_req_t;

  typedef struct packed {
    logic [SX_W-1:0]  sx;
    logic [SY_W-1:0]  sy;
    logic [OFF_W-1:0] offset;
    logic [COL_W-1:0] color;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [XY_W-1:0] in_stage_x = '0;
  logic signed [XY_W-1:0] in_stage_y = '0;
  logic [ID_W-1:0]        in_character_id = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SX_W-1:0]        out_screen_x;
  logic [SY_W-1:0]        out_screen_y;
  logic [OFF_W-1:0]       out_pixel_offset;
  logic [COL_W-1:0]       out_pixel_color;
  logic                   cfg_we = 1'b0;
  logic [0:0]             cfg_index = sdfp_pkg::CFG_STAGE_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // stage size as the block should currently hold it
  logic [CFG_W-1:0] stage_w = '0;
  logic [CFG_W-1:0] stage_h = '0;

  dot_req_t pending_dots[$];
  pixel_t   expected_pixels[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_errors       = 0;
  int n_sent         = 0;
  int n_plotted      = 0;
  int n_cycles       = 0;

  int unsigned fixed_w [N_FIXED] = '{640, 1, 65535, 0, 320, 65535, 1, 550, 400, 0};
  int unsigned fixed_h [N_FIXED] = '{480, 1, 65535, 240, 0, 1, 65535, 400, 240, 0};

  stage_dot_to_framebuffer_plot i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stage_x       (in_stage_x),
    .in_stage_y       (in_stage_y),
    .in_character_id  (in_character_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_color  (out_pixel_color),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_to(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Letterbox fit: truncated 16.16 scale, centered, floored, clamped; a zero stage size clamps directly.
  function automatic pixel_t plot_dot(input dot_req_t d);
    longint s_w;
    longint s_h;
    longint s;
    longint ox;
    longint oy;
    longint cx;
    longint cy;
    logic [31:0] hsh;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    pixel_t      px;
    if (stage_w == 0 || stage_h == 0) begin
      cx = longint'(d.x);
      cy = longint'(d.y);
    end else begin
      s_w = (longint'(SCREEN_WIDTH) << 16) / longint'(stage_w);
      s_h = (longint'(SCREEN_HEIGHT) << 16) / longint'(stage_h);
      s   = (s_w < s_h) ? s_w : s_h;
      ox  = (longint'(SCREEN_WIDTH) - ((longint'(stage_w) * s) >>> 16)) / 2;
      oy  = (longint'(SCREEN_HEIGHT) - ((longint'(stage_h) * s) >>> 16)) / 2;
      cx  = ox + ((longint'(d.x) * s) >>> 16);
      cy  = oy + ((longint'(d.y) * s) >>> 16);
    end
    cx = clamp_to(cx, SCREEN_WIDTH - 1);
    cy = clamp_to(cy, SCREEN_HEIGHT - 1);
    hsh = {16'h0000, d.id} * GOLDEN_MUL;
    r = hsh[23:16] | 8'h40;
    g = hsh[15:8]  | 8'h40;
    b = hsh[7:0]   | 8'h40;
    px.sx     = SX_W'(cx);
    px.sy     = SY_W'(cy);
    px.offset = OFF_W'(cx * SCREEN_HEIGHT + (SCREEN_HEIGHT - 1) - cy);
    px.color  = {r[7:3], g[7:2], b[7:3]};
    return px;
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // input side: predict on acceptance, then present the next dot
  always @(posedge clk) begin : drive
    dot_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.x  = in_stage_x;
        nxt.y  = in_stage_y;
        nxt.id = in_character_id;
        expected_pixels.push_back(plot_dot(nxt));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_dots.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_dots.pop_front();
          in_valid        <= 1'b1;
          in_stage_x      <= nxt.x;
          in_stage_y      <= nxt.y;
          in_character_id <= nxt.id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check each transaction against the oldest prediction
  always @(posedge clk) begin : observe
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected result x=%0d y=%0d off=%0d color=%h",
                                  out_screen_x, out_screen_y, out_pixel_offset,
                                  out_pixel_color));
        end else begin
          want = expected_pixels.pop_front();
          if (out_screen_x !== want.sx)
            note_mismatch($sformatf("result %0d screen_x %0d, want %0d",
                                    n_plotted, out_screen_x, want.sx));
          if (out_screen_y !== want.sy)
            note_mismatch($sformatf("result %0d screen_y %0d, want %0d",
                                    n_plotted, out_screen_y, want.sy));
          if (out_pixel_offset !== want.offset)
            note_mismatch($sformatf("result %0d pixel_offset %0d, want %0d",
                                    n_plotted, out_pixel_offset, want.offset));
          if (out_pixel_color !== want.color)
            note_mismatch($sformatf("result %0d pixel_color %h, want %h",
                                    n_plotted, out_pixel_color, want.color));
        end
        n_plotted++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, expected_pixels.size());
      $display("FAIL stage_dot_to_framebuffer_plot");
      $finish;
    end
  end

  task automatic queue_dot(input logic [31:0] x, input logic [31:0] y,
                           input logic [15:0] id);
    dot_req_t d;
    d.x  = x;
    d.y  = y;
    d.id = id;
    pending_dots.push_back(d);
  endtask

  // mostly on-stage positions, with full-range and edge values mixed in
  function automatic logic [31:0] pick_coord(input int unsigned span);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      3: return 32'd0 - $urandom_range(0, span);
      default: return $urandom_range(0, span + span / 8);
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_dots.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input sdfp_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sdfp_pkg::CFG_STAGE_WIDTH)
      stage_w = val;
    else
      stage_h = val;
    // scale recompute holds off the input side; wait it out
    @(posedge clk);
    @(negedge clk);
    while (!in_ready)
      @(negedge clk);
  endtask

  task automatic queue_directed();
    queue_dot(32'd0, 32'd0, 16'h0000);
    queue_dot(32'd399, 32'd239, 16'hffff);
    queue_dot(32'd400, 32'd240, 16'h0001);
    queue_dot(32'hffff_ffff, 32'hffff_ffff, 16'h8000);
    queue_dot(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    queue_dot(32'h8000_0000, 32'h8000_0000, 16'h0000);
    queue_dot(32'h8000_0000, 32'h7fff_ffff, 16'h5a5a);
    queue_dot(32'hffff_fffe, 32'd5, 16'h1234);
    queue_dot(32'd5, 32'hffff_fffe, 16'habcd);
    queue_dot(32'd200, 32'd120, 16'h00ff);
    queue_dot(32'd1, 32'd1, 16'hff00);
    queue_dot(32'd640, 32'd480, 16'h7fff);
  endtask

  initial begin
    int          p;
    int          k;
    logic [15:0] w;
    logic [15:0] h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      // phase 0 runs on the reset stage size
      if (p > 0) begin
        if (p <= N_FIXED) begin
          w = 16'(fixed_w[p-1]);
          h = 16'(fixed_h[p-1]);
        end else if (p == N_FIXED + 1) begin
          w = 16'($urandom_range(1, 65535));
          h = 16'($urandom_range(1, 2000));
        end else begin
          w = 16'($urandom_range(1, 100));
          h = 16'($urandom_range(1, 100));
        end
        write_reg(sdfp_pkg::CFG_STAGE_WIDTH, w);
        write_reg(sdfp_pkg::CFG_STAGE_HEIGHT, h);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      @(negedge clk);
      if (p < 2)
        queue_directed();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        queue_dot(pick_coord(stage_w != 0 ? stage_w : SCREEN_WIDTH),
                  pick_coord(stage_h != 0 ? stage_h : SCREEN_HEIGHT),
                  16'($urandom_range(0, 65535)));
        // sender holds back mid-phase until the output side has caught up
        if (k == PHASE_ITEMS / 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("plotted %0d of %0d dots over %0d stage sizes (reset, zero, unit, max, mixed)",
             n_plotted, n_sent, N_PHASES);
    $display("stalls on both sides, full-range and edge positions, all ids; %0d mismatches",
             n_errors);
    if (n_errors == 0)
      $display("PASS stage_dot_to_framebuffer_plot");
    else
      $display("FAIL stage_dot_to_framebuffer_plot");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/sdfp_pkg.sv
design/sdfp_scale.sv
design/sdfp_pipe.sv
design/stage_dot_to_framebuffer_plot.sv
sim/tb.sv
